// ===== rtl/core/b64e_pkg.sv =====
`default_nettype none
package b64e_pkg;

    localparam int QueueDepth = 2;
    localparam int QPtrW      = $clog2(QueueDepth);
    localparam int QCntW      = $clog2(QueueDepth + 1);
    localparam int MaxChars   = 4;
    localparam int CharIdxW   = $clog2(MaxChars);

    localparam logic [6:0] PadChar = 7'h3D;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_final;
    } t_in_item;

    typedef struct packed {
        logic [6:0] out_char;
        logic       end_of_text;
    } t_out_item;

    typedef struct packed {
        logic [MaxChars-1:0][6:0] chars;
        logic [CharIdxW-1:0]      last_idx;
        logic                     fin;
    } t_job;

    typedef enum logic [2:0] {
        PH_FIRST  = 3'b001,
        PH_SECOND = 3'b010,
        PH_THIRD  = 3'b100
    } t_phase;

    function automatic logic [6:0] sextet_char(input logic [5:0] v);
        logic [6:0] c;
        if (v < 6'd26) begin
            c = 7'd65 + 7'(v);
        end else if (v < 6'd52) begin
            c = 7'd71 + 7'(v);
        end else if (v < 6'd62) begin
            c = 7'(v) - 7'd4;
        end else if (v == 6'd62) begin
            c = 7'h2B;
        end else begin
            c = 7'h2F;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/b64e_front.sv =====
`default_nettype none
module b64e_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire b64e_pkg::t_in_item i_item,
    output b64e_pkg::t_job         o_job
);

    b64e_pkg::t_phase r_phase, n_phase;
    logic [3:0]       r_res, n_res;
    logic [7:0]       b;
    logic             fin;

    assign b   = i_item.data_byte;
    assign fin = i_item.is_final;

    always_comb begin
        o_job          = '0;
        o_job.fin      = fin;
        n_phase        = r_phase;
        n_res          = r_res;
        unique case (r_phase)
            b64e_pkg::PH_SECOND: begin
                o_job.chars[0] = b64e_pkg::sextet_char({r_res[1:0], b[7:4]});
                o_job.chars[1] = b64e_pkg::sextet_char({b[3:0], 2'b00});
                o_job.chars[2] = b64e_pkg::PadChar;
                o_job.last_idx = fin ? b64e_pkg::CharIdxW'(2) : '0;
                n_res          = b[3:0];
                n_phase        = b64e_pkg::PH_THIRD;
            end
            b64e_pkg::PH_THIRD: begin
                o_job.chars[0] = b64e_pkg::sextet_char({r_res, b[7:6]});
                o_job.chars[1] = b64e_pkg::sextet_char(b[5:0]);
                o_job.last_idx = b64e_pkg::CharIdxW'(1);
                n_res          = '0;
                n_phase        = b64e_pkg::PH_FIRST;
            end
            default: begin
                o_job.chars[0] = b64e_pkg::sextet_char(b[7:2]);
                o_job.chars[1] = b64e_pkg::sextet_char({b[1:0], 4'b0000});
                o_job.chars[2] = b64e_pkg::PadChar;
                o_job.chars[3] = b64e_pkg::PadChar;
                o_job.last_idx = fin ? b64e_pkg::CharIdxW'(3) : '0;
                n_res          = {2'b00, b[1:0]};
                n_phase        = b64e_pkg::PH_SECOND;
            end
        endcase
        if (fin) begin
            n_res   = '0;
            n_phase = b64e_pkg::PH_FIRST;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= b64e_pkg::PH_FIRST;
            r_res   <= '0;
        end else if (i_push) begin
            r_phase <= n_phase;
            r_res   <= n_res;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/b64e_queue.sv =====
`default_nettype none
module b64e_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire b64e_pkg::t_job i_job,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output b64e_pkg::t_job      o_head
);

    b64e_pkg::t_job                r_mem [b64e_pkg::QueueDepth];
    logic [b64e_pkg::QPtrW-1:0]    r_wp;
    logic [b64e_pkg::QPtrW-1:0]    r_rp;
    logic [b64e_pkg::QCntW-1:0]    r_count;
    logic                          push_ok;
    logic                          pop_ok;

    assign o_full  = (r_count == b64e_pkg::QCntW'(b64e_pkg::QueueDepth));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rp];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop_ok) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/b64e_back.sv =====
`default_nettype none
module b64e_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_valid,
    input  wire b64e_pkg::t_job i_q_head,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output b64e_pkg::t_out_item o_out_data
);

    logic [b64e_pkg::CharIdxW-1:0] r_idx;
    logic                          r_out_valid;
    b64e_pkg::t_out_item           r_out;
    logic                          load;
    logic                          take;
    logic                          last;

    assign load  = !r_out_valid || !i_out_stall;
    assign take  = load && i_q_valid;
    assign last  = (r_idx == i_q_head.last_idx);
    assign o_pop = take && last;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (load) begin
                r_out_valid <= i_q_valid;
            end
            if (take) begin
                r_idx <= last ? '0 : r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out.out_char    <= i_q_head.chars[r_idx];
            r_out.end_of_text <= i_q_head.fin && last;
        end
    end

`ifndef SYNTH
    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_valid |-> (r_idx == '0))
        else $error("character index left mid-job with empty queue");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid |-> (r_idx <= i_q_head.last_idx))
        else $error("character index past end of job");

    a_eot_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_q_head.fin && last) |=> (r_out_valid && r_out.end_of_text))
        else $error("final character not marked");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/base64_stream_encoder_top.sv =====
// Streaming base64 encoder, standard alphabet with '=' padding.
// Input channel: i_in_valid / o_in_stall carry one message byte per
// transaction, with is_final set on the message's last byte.
// Output channel: o_out_valid / i_out_stall carry one ASCII character per
// transaction; end_of_text marks the last character of each message.
// A byte yields one character (first or second of a group), two (third of a
// group), or on a final byte the flush plus padding: 4, 3 or 2 characters.
// Each byte is written as a job into the queue; its characters then leave
// through the output register. Throughput: one character per cycle while
// i_out_stall is low, set by the single output register; 4 characters per
// 3 bytes in steady state.
// A two-entry job queue sits between the byte classifier and the character
// sequencer, so bytes are taken while characters drain; o_in_stall rises
// only when both entries are occupied.
// Reset clears the group position, leftover bits, queue and output valid.
// While i_out_stall is high the offered character holds; once the queue
// fills, the input is stalled in turn.
`default_nettype none
module base64_stream_encoder_top (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire b64e_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output b64e_pkg::t_out_item      o_out_data
);

    logic           push;
    logic           q_full;
    logic           q_valid;
    logic           pop;
    b64e_pkg::t_job job;
    b64e_pkg::t_job head;

    assign o_in_stall = q_full;
    assign push       = i_in_valid && !q_full;

    b64e_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_in_data),
        .o_job   (job)
    );

    b64e_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_head  (head)
    );

    b64e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_head    (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

// ===== test/tb_base64_stream_encoder_top.sv =====
module tb_base64_stream_encoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        GRP_FIRST  = 2'd0,
        GRP_SECOND = 2'd1,
        GRP_THIRD  = 2'd2
    } t_grp_pos;

    class b64_scoreboard;
        b64e_pkg::t_out_item expected_chars[$];
        logic [3:0]          leftover;
        t_grp_pos            grp_pos;
        int                  mismatches;
        int                  chars_checked;
        string               alphabet;

        function new();
            leftover      = '0;
            grp_pos       = GRP_FIRST;
            mismatches    = 0;
            chars_checked = 0;
            alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
        endfunction

        function logic [6:0] glyph(input logic [5:0] v);
            return 7'(alphabet[v]);
        endfunction

        task report(input string what);
            $display("MISMATCH at %0t: %s", $time, what);
            mismatches++;
        endtask

        function void note_byte(input b64e_pkg::t_in_item it);
            logic [6:0]          seq[4];
            int                  n;
            logic [7:0]          b;
            b64e_pkg::t_out_item c;
            b = it.data_byte;
            n = 0;
            case (grp_pos)
                GRP_SECOND: begin
                    seq[n++] = glyph({leftover[1:0], b[7:4]});
                    leftover = b[3:0];
                    grp_pos  = GRP_THIRD;
                    if (it.is_final) begin
                        seq[n++] = glyph({b[3:0], 2'b00});
                        seq[n++] = b64e_pkg::PadChar;
                    end
                end
                GRP_THIRD: begin
                    seq[n++] = glyph({leftover, b[7:6]});
                    seq[n++] = glyph(b[5:0]);
                    leftover = '0;
                    grp_pos  = GRP_FIRST;
                end
                default: begin
                    seq[n++] = glyph(b[7:2]);
                    leftover = {2'b00, b[1:0]};
                    grp_pos  = GRP_SECOND;
                    if (it.is_final) begin
                        seq[n++] = glyph({b[1:0], 4'b0000});
                        seq[n++] = b64e_pkg::PadChar;
                        seq[n++] = b64e_pkg::PadChar;
                    end
                end
            endcase
            for (int i = 0; i < n; i++) begin
                c.out_char    = seq[i];
                c.end_of_text = it.is_final && (i == n - 1);
                expected_chars = {expected_chars, c};
            end
            if (it.is_final) begin
                leftover = '0;
                grp_pos  = GRP_FIRST;
            end
        endfunction

        task check_char(input b64e_pkg::t_out_item got);
            b64e_pkg::t_out_item want;
            chars_checked++;
            if (expected_chars.size() == 0) begin
                report($sformatf("unexpected char %02h eot %0b", got.out_char, got.end_of_text));
                return;
            end
            want = expected_chars.pop_front();
            if (got.out_char !== want.out_char)
                report($sformatf("char %0d: out_char %02h, want %02h",
                                 chars_checked, got.out_char, want.out_char));
            if (got.end_of_text !== want.end_of_text)
                report($sformatf("char %0d: end_of_text %0b, want %0b",
                                 chars_checked, got.end_of_text, want.end_of_text));
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    b64e_pkg::t_in_item  i_in_data;
    logic                o_out_valid;
    logic                i_out_stall;
    b64e_pkg::t_out_item o_out_data;

    b64_scoreboard sb;
    bit            in_quiet;
    bit            out_quiet;
    int            bytes_sent;
    int            msgs_sent;

    base64_stream_encoder_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb_base64_stream_encoder_top failed");
        $finish;
    end

    function automatic int draw_gap(input bit quiet);
        if (quiet)
            return 0;
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 18);
        return $urandom_range(0, 2);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                sb.check_char(o_out_data);
            if (i_in_valid && !o_in_stall)
                sb.note_byte(i_in_data);
        end
    end

    initial begin
        int gap;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = draw_gap(out_quiet);
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    task automatic send_byte(input b64e_pkg::t_in_item it);
        int gap;
        gap = draw_gap(in_quiet);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_message(input logic [7:0] msg[$]);
        b64e_pkg::t_in_item it;
        for (int i = 0; i < msg.size(); i++) begin
            it.data_byte = msg[i];
            it.is_final  = (i == msg.size() - 1);
            send_byte(it);
        end
        msgs_sent++;
    endtask

    initial begin
        logic [7:0] msg[$];
        int         len;
        sb         = new();
        bytes_sent = 0;
        msgs_sent  = 0;
        in_quiet   = 1'b0;
        out_quiet  = 1'b0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        msg = '{8'h00};
        send_message(msg);
        msg = '{8'hFF, 8'hFF};
        send_message(msg);
        msg = '{8'hFB, 8'hEF, 8'hFF};
        send_message(msg);
        msg = '{8'h00, 8'hFF, 8'h00, 8'hFF};
        send_message(msg);
        msg = '{8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA};
        send_message(msg);
        msg = '{8'h01, 8'h02, 8'h80, 8'h7F, 8'h40, 8'hC3};
        send_message(msg);

        while (bytes_sent < 222) begin
            in_quiet  = ($urandom_range(0, 4) == 0);
            out_quiet = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(13, 40);
            else
                len = $urandom_range(1, 12);
            msg.delete();
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(0, 9))
                    0:       msg = {msg, 8'h00};
                    1:       msg = {msg, 8'hFF};
                    default: msg = {msg, 8'($urandom_range(0, 255))};
                endcase
            end
            send_message(msg);
        end
        i_in_valid <= 1'b0;

        while (sb.expected_chars.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        $display("Encoded %0d messages, %0d bytes in all, %0d characters checked",
                 msgs_sent, bytes_sent, sb.chars_checked);
        $display("Mismatches: %0d, characters still owed: %0d",
                 sb.mismatches, sb.expected_chars.size());
        if (sb.mismatches == 0 && sb.expected_chars.size() == 0) begin
            $display("tb_base64_stream_encoder_top passed");
        end else begin
            $display("tb_base64_stream_encoder_top failed");
        end
        $finish;
    end
endmodule
